// ----- sv/sitp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitp_pkg: shared types and constants of the string to integer parser
// Item and result records, parser phase codes, register indexes and the
// character classification helpers used by the parser datapath.
// ----------------------------------------------------------------------------
package sitp_pkg;

	localparam int CHAR_W     = 8;
	localparam int RADIX_W    = 6;
	localparam int VALUE_W    = 32;
	localparam int CONSUMED_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int WORD_BITS_DEF = 32;
	localparam int MAX_CHARS_DEF = 65535;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd0;
	localparam logic               SIGNED_RESET = 1'b1;

	// Bases that the prefix logic cares about.
	localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] BASE_2    = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_8    = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_10   = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_16   = 6'd16;

	// ASCII codes.
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

	typedef enum logic [5:0] {
		PH_SPACE  = 6'b000001,
		PH_START  = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_PREFIX = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]    value;
		logic [CONSUMED_W-1:0] consumed;
		logic                  overflow;
		logic                  found_digits;
	} result_t;

	// Digit weight of a character, NO_DIGIT for anything that is not 0-9 or a letter.
	function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = NO_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = c - CH_UA + 8'd10;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = c - CH_LA + 8'd10;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ----- sv/string_to_integer_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_top: streaming string to integer parser
// Accepts one character per cycle unless a final one waits, skips leading
// whitespace, takes a sign and an optional 0x or 0b prefix, accumulates
// digits with saturation and emits value and byte count after the last byte.
// ----------------------------------------------------------------------------
//
//  Channel    Handshake                    Payload
//  ---------  ---------------------------  --------------------------------------
//  character  char_valid / char_ready      character[7:0], last
//  result     result_valid / result_ready  value[31:0], consumed[15:0],
//                                          overflow, found_digits
//  config     cfg_we (write only)          cfg_index[0], cfg_data[5:0]
//
//  Throughput is one character per cycle while no final character waits. A
//  character in the input register has its state update (one multiply-add
//  and range compare) computed there; the result register loads as the
//  final character leaves the input register, and result_valid then rises.
//  Reset clears the parse state and sets radix 0 and signed mode on.
//  A final character waits in the input register only while the result
//  register still holds an untaken result, and char_ready stays low while it
//  waits; a character that is not final never waits.
//
// Register 0 is the radix (0 selects the base from the prefix), register 1
// the signed mode flag. Writes take effect in the next cycle and should only
// be issued while no string is in flight.
// ----------------------------------------------------------------------------
module string_to_integer_parser_top #(
	parameter int WORD_BITS = sitp_pkg::WORD_BITS_DEF,
	parameter int MAX_CHARS = sitp_pkg::MAX_CHARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            char_valid,
	output logic                            char_ready,
	input  logic [sitp_pkg::CHAR_W-1:0]     character,
	input  logic                            last,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [sitp_pkg::VALUE_W-1:0]    value,
	output logic [sitp_pkg::CONSUMED_W-1:0] consumed,
	output logic                            overflow,
	output logic                            found_digits,
	input  logic                            cfg_we,
	input  logic [sitp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sitp_pkg::RADIX_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [sitp_pkg::RADIX_W-1:0] radix_q;
	logic                         signed_mode_q;

	sitp_pkg::item_t   item_in;
	sitp_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              advance;
	logic              res_load;
	logic              out_free;
	sitp_pkg::result_t res_d;
	sitp_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= sitp_pkg::RADIX_RESET;
			signed_mode_q <= sitp_pkg::SIGNED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sitp_pkg::REG_RADIX:       radix_q       <= cfg_data;
				sitp_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign item_in.character = character;
	assign item_in.last      = last;

	// Input register: decouples the source from the state update.
	sitp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.item_in    (item_in),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.advance    (advance)
	);

	// Parse state and per-character step.
	sitp_core #(
		.WORD_BITS (WORD_BITS),
		.MAX_CHARS (MAX_CHARS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.radix       (radix_q),
		.signed_mode (signed_mode_q),
		.out_free    (out_free),
		.advance     (advance),
		.res_load    (res_load),
		.res         (res_d)
	);

	// Result register: keeps a finished result while the next string streams in.
	sitp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_load),
		.res_in       (res_d),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.res_q        (res_q)
	);

	assign value        = res_q.value;
	assign consumed     = res_q.consumed;
	assign overflow     = res_q.overflow;
	assign found_digits = res_q.found_digits;

endmodule

// ----- sv/sitp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitp_in_stage: input register of the parser
// Captures one character transaction and holds it until the core consumes
// it; refills in the same cycle, so one can arrive each cycle it advances.
// ----------------------------------------------------------------------------
module sitp_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_ready,
	input  sitp_pkg::item_t item_in,
	output logic           valid_s1,
	output sitp_pkg::item_t item_s1,
	input  logic           advance
);

	logic valid_q;

	assign char_ready = !valid_q || advance;
	assign valid_s1   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (char_ready) begin
			valid_q <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ----- sv/sitp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitp_core: parser state and combinational character step
// Holds the parse state, advances it by one character per cycle (a final
// one waits for a free result register) and forms the result record from it.
// ----------------------------------------------------------------------------
module sitp_core #(
	parameter int WORD_BITS = sitp_pkg::WORD_BITS_DEF,
	parameter int MAX_CHARS = sitp_pkg::MAX_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  sitp_pkg::item_t               item_s1,
	input  logic [sitp_pkg::RADIX_W-1:0]  radix,
	input  logic                          signed_mode,
	input  logic                          out_free,
	output logic                          advance,
	output logic                          res_load,
	output sitp_pkg::result_t             res
);

	localparam int CNT_W  = $clog2(MAX_CHARS + 1);
	localparam int PROD_W = WORD_BITS + sitp_pkg::RADIX_W;
	localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << (WORD_BITS - 1);
	localparam logic [PROD_W-1:0] UMASK = (PROD_W'(1) << WORD_BITS) - PROD_W'(1);

	sitp_pkg::phase_t        phase_q, phase_n;
	logic [WORD_BITS-1:0]    acc_q, acc_n;
	logic                    neg_q, neg_n;
	logic [sitp_pkg::RADIX_W-1:0] base_q, base_n;
	logic                    ovf_q, ovf_n;
	logic [CNT_W-1:0]        cnt_q, cnt_n;
	logic [CNT_W-1:0]        endp_q, endp_n;
	logic                    any_q, any_n;

	logic [sitp_pkg::CHAR_W-1:0]  ch;
	logic [sitp_pkg::CHAR_W-1:0]  dval;
	logic [sitp_pkg::RADIX_W-1:0] auto_base;
	logic [sitp_pkg::RADIX_W-1:0] tb_raw;
	logic [sitp_pkg::RADIX_W-1:0] tb;
	logic                    take;
	logic                    dig_ok;
	logic                    r_auto, r_two, r_hex;
	logic                    start_case;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]       sum;
	logic [PROD_W-1:0]       limit;
	logic [WORD_BITS-1:0]    word;
	logic                    any_fin;

	assign advance  = valid_s1 && (!item_s1.last || out_free);
	assign res_load = advance && item_s1.last;

	assign r_auto = (radix == sitp_pkg::BASE_AUTO);
	assign r_two  = (radix == sitp_pkg::BASE_2);
	assign r_hex  = (radix == sitp_pkg::BASE_16);

	// Once the byte budget is used up, every byte reads as NUL and is not counted.
	assign ch    = (cnt_q >= CNT_W'(MAX_CHARS)) ? sitp_pkg::CH_NUL : item_s1.character;
	assign cnt_n = (cnt_q >= CNT_W'(MAX_CHARS)) ? cnt_q : cnt_q + CNT_W'(1);
	assign dval  = sitp_pkg::digit_value(ch);

	assign start_case = (phase_q == sitp_pkg::PH_START) ||
		((phase_q == sitp_pkg::PH_SPACE) && !sitp_pkg::is_space(ch) &&
		 ch != sitp_pkg::CH_MINUS && ch != sitp_pkg::CH_PLUS);

	// Shared digit unit: base choice, digit check, multiply-add and range check.
	assign tb     = (tb_raw == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_10 : tb_raw;
	assign dig_ok = dval < {2'b00, tb};
	assign prod   = {{sitp_pkg::RADIX_W{1'b0}}, acc_q} * {{WORD_BITS{1'b0}}, tb};
	assign sum    = prod + PROD_W'(dval[sitp_pkg::RADIX_W-1:0]);
	assign limit  = signed_mode ? (neg_q ? HALF : HALF - PROD_W'(1)) : UMASK;

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		base_n    = base_q;
		ovf_n     = ovf_q;
		endp_n    = endp_q;
		any_n     = any_q;
		take      = 1'b0;
		tb_raw    = base_q;
		auto_base = r_auto ? sitp_pkg::BASE_10 : radix;

		case (phase_q)
			sitp_pkg::PH_SPACE, sitp_pkg::PH_START: begin
				if (phase_q == sitp_pkg::PH_SPACE && ch == sitp_pkg::CH_MINUS) begin
					neg_n   = 1'b1;
					phase_n = sitp_pkg::PH_START;
				end else if (phase_q == sitp_pkg::PH_SPACE && ch == sitp_pkg::CH_PLUS) begin
					phase_n = sitp_pkg::PH_START;
				end else if (start_case) begin
					if (ch == sitp_pkg::CH_ZERO && (r_auto || r_two || r_hex)) begin
						phase_n = sitp_pkg::PH_ZERO;
						endp_n  = cnt_n;
					end else begin
						base_n = auto_base;
						tb_raw = auto_base;
						take   = 1'b1;
					end
				end
			end
			sitp_pkg::PH_ZERO: begin
				if ((ch == sitp_pkg::CH_LX || ch == sitp_pkg::CH_UX) && (r_auto || r_hex)) begin
					base_n  = sitp_pkg::BASE_16;
					phase_n = sitp_pkg::PH_PREFIX;
				end else if ((ch == sitp_pkg::CH_LB || ch == sitp_pkg::CH_UB) &&
				             (r_auto || r_two)) begin
					base_n  = sitp_pkg::BASE_2;
					phase_n = sitp_pkg::PH_PREFIX;
				end else begin
					base_n = r_auto ? sitp_pkg::BASE_8 : radix;
					tb_raw = r_auto ? sitp_pkg::BASE_8 : radix;
					any_n  = 1'b1;
					take   = 1'b1;
				end
			end
			sitp_pkg::PH_PREFIX, sitp_pkg::PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
			end
		endcase

		if (take) begin
			if (!dig_ok) begin
				phase_n = sitp_pkg::PH_DONE;
			end else begin
				phase_n = sitp_pkg::PH_DIGITS;
				if (ovf_q || sum > limit) begin
					ovf_n = 1'b1;
				end else begin
					acc_n = sum[WORD_BITS-1:0];
				end
				any_n  = 1'b1;
				endp_n = cnt_n;
			end
		end
	end

	// Result formation for the final character.
	assign any_fin = any_n || (phase_n == sitp_pkg::PH_ZERO);

	always_comb begin
		if (ovf_n) begin
			if (signed_mode) begin
				word = neg_n ? HALF[WORD_BITS-1:0] : HALF[WORD_BITS-1:0] - WORD_BITS'(1);
			end else begin
				word = UMASK[WORD_BITS-1:0];
			end
		end else begin
			word = neg_n ? (~acc_n) + WORD_BITS'(1) : acc_n;
		end
		res.value        = sitp_pkg::VALUE_W'(word);
		res.consumed     = any_fin ? sitp_pkg::CONSUMED_W'(endp_n) : '0;
		res.overflow     = ovf_n;
		res.found_digits = any_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sitp_pkg::PH_SPACE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			endp_q  <= '0;
			any_q   <= 1'b0;
		end else if (advance) begin
			if (item_s1.last) begin
				phase_q <= sitp_pkg::PH_SPACE;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				base_q  <= '0;
				ovf_q   <= 1'b0;
				cnt_q   <= '0;
				endp_q  <= '0;
				any_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				ovf_q   <= ovf_n;
				cnt_q   <= cnt_n;
				endp_q  <= endp_n;
				any_q   <= any_n;
			end
		end
	end

	// A finished string always leaves the parser back in its whitespace phase.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last |=> phase_q == sitp_pkg::PH_SPACE && acc_q == '0 && !any_q)
		else $error("parser state not cleared after final character");

	// Overflow is sticky within a string.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(advance && item_s1.last) |=> ovf_q)
		else $error("overflow flag dropped in the middle of a string");

	// A digit has been taken only once the parser reached the digit or done phase.
	a_digit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> phase_q == sitp_pkg::PH_DIGITS || phase_q == sitp_pkg::PH_DONE)
		else $error("digit flag set outside digit phases");

	// The byte count never passes its budget, and the end position never passes the count.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CHARS) && endp_q <= cnt_q)
		else $error("character count out of range");

endmodule

// ----- sv/sitp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitp_out_stage: result register of the parser
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module sitp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sitp_pkg::result_t res_in,
	output logic              out_free,
	output logic              result_valid,
	input  logic              result_ready,
	output sitp_pkg::result_t res_q
);

	logic valid_q;

	assign out_free     = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ----- tb/sv/tb_string_to_integer_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_to_integer_parser_top: self-checking bench for the string parser
// Streams character strings into the parser under several radix and sign
// settings and compares every parse result against an in-bench model of the
// parser that tracks each accepted character transaction.
// ----------------------------------------------------------------------------
module tb_string_to_integer_parser_top;

	// The run is cut off here if results stop arriving. The slowest legal run
	// (the long string plus the random part, every character delayed by a gap
	// and every result by a stall) stays well below this limit.
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	// Signed and unsigned saturation bounds of the 32-bit word.
	localparam longint unsigned WORD_ALL = (64'd1 << sitp_pkg::VALUE_W) - 64'd1;
	localparam longint unsigned WORD_HALF = 64'd1 << (sitp_pkg::VALUE_W - 1);

	// Least number of characters sent in each random round.
	localparam int unsigned ROUND_CHARS = 165;

	typedef logic [sitp_pkg::CHAR_W-1:0] text_t[$];

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            char_valid;
	logic                            char_ready;
	logic [sitp_pkg::CHAR_W-1:0]     character;
	logic                            last;
	logic                            result_valid;
	logic                            result_ready;
	logic [sitp_pkg::VALUE_W-1:0]    value;
	logic [sitp_pkg::CONSUMED_W-1:0] consumed;
	logic                            overflow;
	logic                            found_digits;
	logic                            cfg_we;
	logic [sitp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sitp_pkg::RADIX_W-1:0]    cfg_data;

	// When calm is set, neither the character source nor the result sink idles.
	bit          calm = 1'b0;
	int unsigned sent_chars = 0;
	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	// Radix last written, used only to shape the generated digits.
	int unsigned gen_radix = 0;

	// Parser model state, mirrored from the accepted character transactions.
	sitp_pkg::phase_t  ph;
	logic [31:0]       acc;
	logic              is_neg;
	logic [5:0]        num_base;
	logic              saturated;
	logic [15:0]       char_cnt;
	logic [15:0]       stop_pos;
	logic              seen_digit;
	logic [5:0]        radix_q;
	logic              signed_q;
	sitp_pkg::result_t pending_parses[$];

	string_to_integer_parser_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.character   (character),
		.last        (last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.value       (value),
		.consumed    (consumed),
		.overflow    (overflow),
		.found_digits(found_digits),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------

	// Weight of a digit character, 255 for anything that is not 0-9 or a letter.
	// Setting bit 5 folds upper case onto lower case and maps no other byte
	// into the lower case letter range.
	function automatic int unsigned char_weight(input logic [sitp_pkg::CHAR_W-1:0] c);
		logic [sitp_pkg::CHAR_W-1:0] folded;
		int unsigned                 w;
		folded = c | 8'h20;
		w = 255;
		if (c >= sitp_pkg::CH_ZERO && c <= sitp_pkg::CH_NINE) begin
			w = 32'(c - sitp_pkg::CH_ZERO);
		end else if (folded >= sitp_pkg::CH_LA && folded <= sitp_pkg::CH_LZ) begin
			w = 32'(folded - sitp_pkg::CH_LA) + 10;
		end
		return w;
	endfunction

	// Largest magnitude the current mode and sign allow.
	function automatic longint unsigned range_top();
		if (!signed_q) begin
			return WORD_ALL;
		end
		return is_neg ? WORD_HALF : WORD_HALF - 64'd1;
	endfunction

	function automatic void restart_parse();
		ph = sitp_pkg::PH_SPACE;
		acc = '0;
		is_neg = 1'b0;
		num_base = '0;
		saturated = 1'b0;
		char_cnt = '0;
		stop_pos = '0;
		seen_digit = 1'b0;
	endfunction

	// Accumulate one digit, or end the number if the weight is not below the base.
	// Once saturated, further digits only move the end position.
	function automatic void take_weight(input int unsigned d);
		longint unsigned base;
		longint unsigned top;
		longint unsigned grown;
		base = (num_base != 0) ? 64'(num_base) : 64'd10;
		if (d >= base) begin
			ph = sitp_pkg::PH_DONE;
			return;
		end
		ph = sitp_pkg::PH_DIGITS;
		top = range_top();
		if (saturated || acc > top / base || (acc == top / base && d > top % base)) begin
			saturated = 1'b1;
		end else begin
			grown = acc * base + d;
			acc = grown[31:0];
		end
		seen_digit = 1'b1;
		stop_pos = char_cnt;
	endfunction

	// First character after whitespace and sign. A leading zero may still turn
	// into a 0x or 0b prefix if the radix allows one.
	function automatic void begin_number(input logic [sitp_pkg::CHAR_W-1:0] c);
		if (c == sitp_pkg::CH_ZERO && (radix_q == sitp_pkg::BASE_AUTO ||
				radix_q == sitp_pkg::BASE_2 || radix_q == sitp_pkg::BASE_16)) begin
			ph = sitp_pkg::PH_ZERO;
			stop_pos = char_cnt;
		end else begin
			num_base = (radix_q == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_10 : radix_q;
			take_weight(char_weight(c));
		end
	endfunction

	function automatic void parse_char(input logic [sitp_pkg::CHAR_W-1:0] ch,
		input logic is_last);
		logic [sitp_pkg::CHAR_W-1:0] c;
		sitp_pkg::result_t           res;
		c = ch;
		// Past the length limit every byte behaves as a terminating NUL.
		if (char_cnt >= sitp_pkg::MAX_CHARS_DEF) begin
			c = sitp_pkg::CH_NUL;
		end else begin
			char_cnt = char_cnt + 16'd1;
		end
		case (ph)
			sitp_pkg::PH_SPACE: begin
				if (c == sitp_pkg::CH_MINUS) begin
					is_neg = 1'b1;
					ph = sitp_pkg::PH_START;
				end else if (c == sitp_pkg::CH_PLUS) begin
					ph = sitp_pkg::PH_START;
				end else if (!(c == sitp_pkg::CH_SPACE ||
						(c >= sitp_pkg::CH_TAB && c <= sitp_pkg::CH_CR))) begin
					begin_number(c);
				end
			end
			sitp_pkg::PH_START: begin
				begin_number(c);
			end
			sitp_pkg::PH_ZERO: begin
				if ((c == sitp_pkg::CH_LX || c == sitp_pkg::CH_UX) &&
						(radix_q == sitp_pkg::BASE_AUTO || radix_q == sitp_pkg::BASE_16)) begin
					num_base = sitp_pkg::BASE_16;
					ph = sitp_pkg::PH_PREFIX;
				end else if ((c == sitp_pkg::CH_LB || c == sitp_pkg::CH_UB) &&
						(radix_q == sitp_pkg::BASE_AUTO || radix_q == sitp_pkg::BASE_2)) begin
					num_base = sitp_pkg::BASE_2;
					ph = sitp_pkg::PH_PREFIX;
				end else begin
					num_base = (radix_q == sitp_pkg::BASE_AUTO) ? sitp_pkg::BASE_8 : radix_q;
					seen_digit = 1'b1;
					take_weight(char_weight(c));
				end
			end
			sitp_pkg::PH_PREFIX, sitp_pkg::PH_DIGITS: begin
				take_weight(char_weight(c));
			end
			default: begin
			end
		endcase
		if (is_last) begin
			// A lone zero still waiting for a prefix letter counts as a digit.
			if (ph == sitp_pkg::PH_ZERO) begin
				seen_digit = 1'b1;
			end
			if (saturated) begin
				res.value = 32'(range_top());
			end else begin
				res.value = is_neg ? (~acc) + 32'd1 : acc;
			end
			res.consumed = seen_digit ? stop_pos : '0;
			res.overflow = saturated;
			res.found_digits = seen_digit;
			pending_parses.push_back(res);
			restart_parse();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Monitor: configuration writes and character transactions update the
	// model first, then a result transaction at the same edge is compared
	// with the oldest pending parse. All reads happen at the rising edge,
	// before the design's registers update.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		sitp_pkg::result_t want;
		if (!arst_n) begin
			radix_q = sitp_pkg::RADIX_RESET;
			signed_q = sitp_pkg::SIGNED_RESET;
			restart_parse();
			pending_parses.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == sitp_pkg::REG_RADIX) begin
					radix_q = cfg_data;
				end else if (cfg_index == sitp_pkg::REG_SIGNED_MODE) begin
					signed_q = cfg_data[0];
				end
			end
			if (char_valid && char_ready) begin
				parse_char(character, last);
			end
			if (result_valid && result_ready) begin
				if (pending_parses.size() == 0) begin
					$error("result with no parse pending: value %h consumed %0d",
						value, consumed);
					failures++;
				end else begin
					want = pending_parses.pop_front();
					if (value !== want.value) begin
						$error("value: expected %h, got %h", want.value, value);
						failures++;
					end
					if (consumed !== want.consumed) begin
						$error("consumed: expected %0d, got %0d", want.consumed, consumed);
						failures++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %b, got %b", want.overflow, overflow);
						failures++;
					end
					if (found_digits !== want.found_digits) begin
						$error("found_digits: expected %b, got %b",
							want.found_digits, found_digits);
						failures++;
					end
				end
			end
		end
	end

	// The result sink stalls in short random bursts until the final round.
	initial begin : result_sink
		int unsigned hold;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				result_ready = 1'b0;
				hold = $urandom_range(1, 3);
				repeat (hold - 1) @(negedge clk);
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Sends one character transaction. The source may idle for a short burst
	// first; otherwise valid stays high straight from the previous transaction.
	task automatic send_char(input logic [sitp_pkg::CHAR_W-1:0] c, input logic is_last);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			char_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		char_valid = 1'b1;
		character = c;
		last = is_last;
		do @(posedge clk); while (!char_ready);
		sent_chars++;
	endtask

	// Sends a whole string with last set on its final character.
	task automatic send_text(input text_t t);
		int unsigned i;
		for (i = 0; i < t.size(); i++) begin
			send_char(t[i], i == t.size() - 1);
		end
	endtask

	task automatic send_string(input string s);
		text_t t;
		int    i;
		for (i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		send_text(t);
	endtask

	// Stops the character source and waits until every parse has come back.
	task automatic drain_results();
		@(negedge clk);
		char_valid = 1'b0;
		while (pending_parses.size() != 0) @(posedge clk);
	endtask

	// Idle point for register writes: drained, plus margin so that no string
	// is left in flight.
	task automatic settle();
		drain_results();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sitp_pkg::CFG_IDX_W-1:0] idx,
		input logic [sitp_pkg::RADIX_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == sitp_pkg::REG_RADIX) begin
			gen_radix = 32'(data);
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// One of the six whitespace characters.
	function automatic logic [sitp_pkg::CHAR_W-1:0] blank();
		int unsigned k;
		k = $urandom_range(0, 5);
		return (k == 5) ? sitp_pkg::CH_SPACE : sitp_pkg::CH_TAB + 8'(k);
	endfunction

	// A well-formed number with random content: optional whitespace, sign and
	// prefix, a run of digits valid for the base, and some random trailing
	// bytes that may be digits. Long runs push the value into saturation.
	task automatic send_number();
		text_t       t;
		int unsigned b;
		int unsigned pick;
		int unsigned n;
		int unsigned d;
		repeat ($urandom_range(0, 2)) t.push_back(blank());
		pick = $urandom_range(0, 3);
		if (pick == 0) begin
			t.push_back(sitp_pkg::CH_MINUS);
		end else if (pick == 1) begin
			t.push_back(sitp_pkg::CH_PLUS);
		end
		b = gen_radix;
		pick = $urandom_range(0, 3);
		if ((b == sitp_pkg::BASE_AUTO || b == sitp_pkg::BASE_16) && pick == 0) begin
			t.push_back(sitp_pkg::CH_ZERO);
			t.push_back($urandom_range(0, 1) ? sitp_pkg::CH_LX : sitp_pkg::CH_UX);
			b = 32'(sitp_pkg::BASE_16);
		end else if ((b == sitp_pkg::BASE_AUTO || b == sitp_pkg::BASE_2) && pick == 1) begin
			t.push_back(sitp_pkg::CH_ZERO);
			t.push_back($urandom_range(0, 1) ? sitp_pkg::CH_LB : sitp_pkg::CH_UB);
			b = 32'(sitp_pkg::BASE_2);
		end else if (b == sitp_pkg::BASE_AUTO && pick == 2) begin
			t.push_back(sitp_pkg::CH_ZERO);
			b = 32'(sitp_pkg::BASE_8);
		end else if (b == sitp_pkg::BASE_AUTO) begin
			b = 32'(sitp_pkg::BASE_10);
		end
		// Above 36 every letter is a digit, so the widest digit set is the same.
		if (b > 36) begin
			b = 36;
		end
		n = $urandom_range(1, b <= 2 ? 36 : b <= 8 ? 13 : b <= 10 ? 12 : b <= 16 ? 10 : 8);
		repeat (n) begin
			d = $urandom_range(0, b - 1);
			if (d < 10) begin
				t.push_back(sitp_pkg::CH_ZERO + 8'(d));
			end else begin
				t.push_back(($urandom_range(0, 1) ? sitp_pkg::CH_LA : sitp_pkg::CH_UA) +
					8'(d - 10));
			end
		end
		repeat ($urandom_range(0, 2)) t.push_back(8'($urandom_range(0, 255)));
		send_text(t);
	endtask

	// Short random strings built from the characters that steer the parser:
	// whitespace, signs, zeros, prefix letters, digits and arbitrary bytes.
	task automatic send_noise();
		text_t t;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 7))
				0: t.push_back(blank());
				1: t.push_back(sitp_pkg::CH_MINUS);
				2: t.push_back(sitp_pkg::CH_PLUS);
				3: t.push_back(sitp_pkg::CH_ZERO);
				4: t.push_back($urandom_range(0, 1) ? sitp_pkg::CH_LX : sitp_pkg::CH_UB);
				5: t.push_back(sitp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				default: t.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		send_text(t);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset settings (radix detected from the prefix, signed mode): a hex
	// prefix after a sign, a bare binary prefix with no digit, a lone zero at
	// the end of the string, and a number followed by the extreme bytes.
	task automatic test_reset_config();
		text_t tail;
		send_string(" -0x1g");
		send_string("0b");
		send_string("0");
		tail = '{sitp_pkg::CH_ZERO + 8'd7, 8'hFF, sitp_pkg::CH_NUL};
		send_text(tail);
	endtask

	// Signed saturation in both directions, unsigned saturation, the unsigned
	// minus, a radix above 36 and the radix that only takes zeros.
	task automatic test_saturation();
		settle();
		write_reg(sitp_pkg::REG_RADIX, 6'd36);
		write_reg(sitp_pkg::REG_SIGNED_MODE, 6'd1);
		send_string("zzzzzz");
		send_string("-zzzzzz");
		settle();
		write_reg(sitp_pkg::REG_SIGNED_MODE, 6'd0);
		send_string("zzzzzzz");
		settle();
		write_reg(sitp_pkg::REG_RADIX, 6'd63);
		send_string("-Z~");
		settle();
		write_reg(sitp_pkg::REG_RADIX, 6'd1);
		send_string("001");
		settle();
		write_reg(sitp_pkg::REG_RADIX, sitp_pkg::BASE_AUTO);
		write_reg(sitp_pkg::REG_SIGNED_MODE, 6'd1);
	endtask

	// A string longer than the character limit. The digits straddle the limit,
	// so the count stops at the limit and the number ends there.
	task automatic test_long_string();
		repeat (sitp_pkg::MAX_CHARS_DEF - 5) send_char(sitp_pkg::CH_SPACE, 1'b0);
		send_string("123456789");
	endtask

	// Random rounds, each under its own register setting. Most strings are
	// well-formed numbers; the rest are noise. Now and then the source waits
	// for all results before going on. The last round runs without idling.
	task automatic test_random_mix();
		int unsigned                  round;
		int unsigned                  goal;
		logic [sitp_pkg::RADIX_W-1:0] menu[8];
		menu = '{sitp_pkg::BASE_AUTO, sitp_pkg::BASE_10, sitp_pkg::BASE_16,
			sitp_pkg::BASE_2, sitp_pkg::BASE_8, 6'd36, 6'd1, sitp_pkg::BASE_AUTO};
		for (round = 0; round < 10; round++) begin
			settle();
			if (round == 9) begin
				calm = 1'b1;
			end
			write_reg(sitp_pkg::REG_RADIX,
				round < 8 ? menu[round] : 6'($urandom_range(0, 63)));
			write_reg(sitp_pkg::REG_SIGNED_MODE, 6'($urandom_range(0, 1)));
			goal = sent_chars + ROUND_CHARS;
			while (sent_chars < goal) begin
				if ($urandom_range(0, 4) == 0) begin
					send_noise();
				end else begin
					send_number();
				end
				if ($urandom_range(0, 59) == 0) begin
					drain_results();
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// Every input is known from time zero, while reset is held.
		arst_n = 1'b0;
		char_valid = 1'b0;
		character = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_saturation();
		test_long_string();
		test_random_mix();

		// Wait for the last results, then a few more cycles to catch any
		// result the parser should not have produced.
		settle();
		repeat (8) @(posedge clk);
		if (failures == 0 && pending_parses.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/sitp_pkg.sv
sv/sitp_in_stage.sv
sv/sitp_core.sv
sv/sitp_out_stage.sv
sv/string_to_integer_parser_top.sv
tb/sv/tb_string_to_integer_parser_top.sv
